[rtl/fixed_point_q24_8_alu_core_assert.svh]
// assertion macros for the q24.8 alu core
// no dependencies; expects clk and rst in the scope of use
`ifndef FIXED_POINT_Q24_8_ALU_CORE_ASSERT_SVH
`define FIXED_POINT_Q24_8_ALU_CORE_ASSERT_SVH

// same-cycle implication
`define Q248_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("q248alu assertion failed");

// next-cycle implication
`define Q248_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("q248alu assertion failed");

`endif

[rtl/q248alu_pkg.sv]
// shared types and constants for the q24.8 alu core
// no dependencies
`timescale 1ns / 1ps
package q248alu_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int DIV_STEP_BITS = 4;   // quotient bits per divider stage

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_MIN = 4'd4,
    OP_MAX = 4'd5,
    OP_INC = 4'd6,
    OP_DEC = 4'd7,
    OP_I2F = 4'd8,
    OP_TOI = 4'd9
  } op_t;

  typedef struct packed {
    logic less;
    logic greater;
    logic equal;
  } cmp_t;

  typedef struct packed {
    logic [3:0]         op;
    cmp_t               cmp;
    logic [31:0]        simple_res;
    logic               simple_ovf;
    logic signed [63:0] prod;
    logic               neg;
    logic               dz;
  } side_t;

endpackage

[rtl/fixed_point_q24_8_alu_core.sv]
// q24.8 fixed-point alu: stage a, then the divider stages, then the final
// output register; the divider stages set the depth
// one request per cycle unless the output stalls; a stall freezes every stage
// rst (synchronous, active high) clears all stage valid bits; payload is not reset
// depends on q248alu_pkg, q248alu_div and fixed_point_q24_8_alu_core_assert.svh
`timescale 1ns / 1ps
module fixed_point_q24_8_alu_core
  import q248alu_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // operand_a [31:0], operand_b [63:32]
  input  logic [3:0]  s_tuser,   // req_type [3:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // result, a_less, a_greater, a_equal,
                                 // div_by_zero, overflow, zero fill
);

  localparam int DW = 32 + FRAC_BITS;
  localparam int NS = (DW + DIV_STEP_BITS - 1) / DIV_STEP_BITS;

  // whole pipe moves together; the output register is the last stage
  // no request is taken while reset is held
  logic ce;
  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce && !rst;

  // ---------------- stage a: decode, compare, simple ops, multiply
  logic signed [31:0] a, b;
  logic signed [63:0] a64, b64, r64;
  logic [31:0]        a_mag, b_mag;
  side_t              side_a;

  assign a     = s_tdata[31:0];
  assign b     = s_tdata[63:32];
  assign a64   = 64'(a);
  assign b64   = 64'(b);
  assign a_mag = a[31] ? 32'(-a) : 32'(a);
  assign b_mag = b[31] ? 32'(-b) : 32'(b);

  always_comb begin
    unique case (op_t'(s_tuser))
      OP_ADD:  r64 = a64 + b64;
      OP_SUB:  r64 = a64 - b64;
      OP_MIN:  r64 = (a < b) ? a64 : b64;
      OP_MAX:  r64 = (a > b) ? a64 : b64;
      OP_INC:  r64 = a64 + 64'sd1;
      OP_DEC:  r64 = a64 - 64'sd1;
      OP_I2F:  r64 = a64 <<< FRAC_BITS;
      OP_TOI:  r64 = a64 >>> FRAC_BITS;
      default: r64 = '0;   // mul, div and unused codes
    endcase
  end

  always_comb begin
    side_a.op          = s_tuser;
    side_a.cmp.less    = a < b;
    side_a.cmp.greater = a > b;
    side_a.cmp.equal   = a == b;
    side_a.simple_res  = r64[31:0];
    side_a.simple_ovf  = r64 != 64'(signed'(r64[31:0]));
    side_a.prod        = a64 * b64;   // 32x32 signed, registered below
    side_a.neg         = a[31] ^ b[31];
    side_a.dz          = (b == 32'sd0);
  end

  side_t          side_q [NS+1];
  logic [NS:0]    vld;
  logic [DW-1:0]  dvd_q;
  logic [31:0]    dvs_q;
  logic [DW-1:0]  quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[NS-1:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      side_q[0] <= side_a;
      dvd_q     <= {a_mag, {FRAC_BITS{1'b0}}};
      dvs_q     <= b_mag;
      for (int k = 1; k <= NS; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // ---------------- divider stages: magnitude quotient of (|a| << frac) / |b|
  q248alu_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .ce       (ce),
    .dividend (dvd_q),
    .divisor  (dvs_q),
    .quotient (quot)
  );

  // ---------------- final stage: shift product, sign quotient, select
  side_t              sd;
  logic signed [63:0] ps;
  logic [63:0]        q64;
  logic [31:0]        res_next;
  logic               ovf_next;
  logic               dz_next;

  assign sd  = side_q[NS];
  assign ps  = sd.prod >>> FRAC_BITS;   // floor shift of the full product
  assign q64 = 64'(quot);

  always_comb begin
    dz_next = 1'b0;
    unique case (op_t'(sd.op))
      OP_MUL: begin
        res_next = ps[31:0];
        ovf_next = ps != 64'(signed'(ps[31:0]));
      end
      OP_DIV: begin
        if (sd.dz) begin
          // zero divisor gives a zero result and no overflow
          res_next = '0;
          ovf_next = 1'b0;
          dz_next  = 1'b1;
        end else begin
          res_next = sd.neg ? 32'(-quot[31:0]) : quot[31:0];
          ovf_next = sd.neg ? (q64 > 64'h0000_0000_8000_0000)
                            : (q64 > 64'h0000_0000_7FFF_FFFF);
        end
      end
      default: begin
        res_next = sd.simple_res;
        ovf_next = sd.simple_ovf;
      end
    endcase
  end

  logic [31:0] res_q;
  cmp_t        cmp_q;
  logic        dz_q;
  logic        ovf_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ce) begin
      m_tvalid <= vld[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      res_q <= res_next;
      cmp_q <= sd.cmp;
      dz_q  <= dz_next;
      ovf_q <= ovf_next;
    end
  end

  assign m_tdata = {3'b000, ovf_q, dz_q, cmp_q.equal, cmp_q.greater, cmp_q.less, res_q};

  // ---------------- checks
  `include "fixed_point_q24_8_alu_core_assert.svh"

  `Q248_ASSERT_IMP(a_dz_clean, m_tvalid && dz_q, (res_q == 32'd0) && !ovf_q)
  `Q248_ASSERT_IMP(a_cmp_onehot, m_tvalid, $onehot({cmp_q.less, cmp_q.greater, cmp_q.equal}))
  `Q248_ASSERT_NXT(a_stall_freeze, m_tvalid && !m_tready, $stable(vld))

endmodule

[rtl/q248alu_div.sv]
// pipelined restoring divider, unsigned, DIV_STEP_BITS quotient bits per stage
// depends on q248alu_pkg
`timescale 1ns / 1ps
module q248alu_div
  import q248alu_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      ce,
  input  logic [32+FRAC_BITS-1:0]   dividend,
  input  logic [31:0]               divisor,
  output logic [32+FRAC_BITS-1:0]   quotient
);

  localparam int DW = 32 + FRAC_BITS;
  localparam int NS = (DW + DIV_STEP_BITS - 1) / DIV_STEP_BITS;

  logic [31:0]   rem_q  [NS];
  logic [DW-1:0] work_q [NS];
  logic [31:0]   dvs_q  [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int STEPS = (DW - s * DIV_STEP_BITS < DIV_STEP_BITS) ?
                           (DW - s * DIV_STEP_BITS) : DIV_STEP_BITS;
    logic [31:0]   rem_in, rem_nx;
    logic [DW-1:0] work_in, work_nx;
    logic [31:0]   dvs_in;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign work_in = dividend;
      assign dvs_in  = divisor;
    end else begin : g_rest
      assign rem_in  = rem_q[s-1];
      assign work_in = work_q[s-1];
      assign dvs_in  = dvs_q[s-1];
    end

    always_comb begin
      logic [32:0] t;
      rem_nx  = rem_in;
      work_nx = work_in;
      t       = '0;
      for (int i = 0; i < STEPS; i++) begin
        t       = {rem_nx, work_nx[DW-1]};
        work_nx = {work_nx[DW-2:0], 1'b0};
        if (t >= {1'b0, dvs_in}) begin
          t          = t - {1'b0, dvs_in};
          work_nx[0] = 1'b1;
        end
        rem_nx = t[31:0];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem_q[s]  <= rem_nx;
        work_q[s] <= work_nx;
        dvs_q[s]  <= dvs_in;
      end
    end
  end

  assign quotient = work_q[NS-1];

endmodule
